// ===== hw/rtl/keyboard_serial_responder_unit_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef KEYBOARD_SERIAL_RESPONDER_UNIT_MACROS_SVH
`define KEYBOARD_SERIAL_RESPONDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define KSRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyboard responder check failed");

// Next-cycle implication, disabled while reset is low.
`define KSRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyboard responder check failed");

`endif

// ===== hw/rtl/kbsr_pkg.sv =====
package kbsr_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int BITS_PER_BYTE = 8;
    localparam int QIDX_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W         = 7;
    localparam int QCOUNT_OUT_W  = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] LAST_TICK = CNT_W'(2 * BITS_PER_BYTE - 1);

    localparam logic [7:0] CMD_INQUIRY  = 8'h10;
    localparam logic [7:0] CMD_INSTANT  = 8'h14;
    localparam logic [7:0] CMD_MODEL    = 8'h16;
    localparam logic [7:0] CMD_TEST     = 8'h36;
    localparam logic [7:0] REPLY_ACK    = 8'h7D;
    localparam logic [7:0] REPLY_MODEL  = 8'h0B;
    localparam logic [7:0] REPLY_RESET  = 8'h09;
    localparam logic [7:0] EMPTY_CODE_RST = 8'd123;
    localparam logic [7:0] POLL_LIMIT_RST = 8'd100;

    typedef enum logic [1:0] {
        FUNC_EDGE = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_PUSH = 2'd2,
        FUNC_NOP  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_RX_TIMING = 3'd1,
        ACT_TX_TIMING = 3'd2,
        ACT_POLL      = 3'd3,
        ACT_TX_PERIOD = 3'd4,
        ACT_STOP      = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        WATCH_KEEP    = 2'd0,
        WATCH_FALLING = 2'd1,
        WATCH_RISING  = 2'd2,
        WATCH_STOP    = 2'd3
    } t_watch;

    typedef enum logic [2:0] {
        PCODE_WAIT_RX  = 3'd0,
        PCODE_RECEIVE  = 3'd1,
        PCODE_WAIT_TX  = 3'd2,
        PCODE_POLL     = 3'd3,
        PCODE_TRANSMIT = 3'd4
    } t_phase_code;

    typedef enum logic [4:0] {
        PH_WAIT_RX  = 5'b00001,
        PH_RECEIVE  = 5'b00010,
        PH_WAIT_TX  = 5'b00100,
        PH_POLL     = 5'b01000,
        PH_TRANSMIT = 5'b10000
    } t_phase;

    typedef enum logic {
        CFG_EMPTY_CODE = 1'b0,
        CFG_POLL_LIMIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] func;
        logic       data_line_level;
        logic [7:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic       clock_level;
        logic       data_out_level;
        logic       data_drive;
        logic [2:0] timer_action;
        logic [1:0] edge_watch;
        logic       push_accepted;
        logic [4:0] queue_count;
        logic [2:0] phase;
    } t_out_item;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] code;
    } t_q_req;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [7:0]        head_code;
        logic [QCNT_W-1:0] used;
    } t_q_stat;

    function automatic logic [2:0] phase_code(t_phase ph);
        logic [2:0] code;
        unique case (ph)
            PH_WAIT_RX:  code = PCODE_WAIT_RX;
            PH_RECEIVE:  code = PCODE_RECEIVE;
            PH_WAIT_TX:  code = PCODE_WAIT_TX;
            PH_POLL:     code = PCODE_POLL;
            PH_TRANSMIT: code = PCODE_TRANSMIT;
            default:     code = PCODE_WAIT_RX;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/kbsr_queue.sv =====
module kbsr_queue
    import kbsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_req  i_req,
    output t_q_stat o_stat
);

    localparam int SUM_W = QIDX_W + 1;

    logic [7:0]        r_store [QUEUE_DEPTH];
    logic [QIDX_W-1:0] r_head;
    logic [QCNT_W-1:0] r_used;
    logic [QIDX_W-1:0] n_head;
    logic [QCNT_W-1:0] n_used;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  tail_wrap;
    logic [QIDX_W-1:0] tail;
    logic              full;
    logic              empty;

    assign full  = (r_used == QCNT_W'(QUEUE_DEPTH));
    assign empty = (r_used == '0);

    // tail = (head + used) mod depth, sum stays below twice the depth
    assign tail_sum  = SUM_W'(r_head) + SUM_W'(r_used);
    assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       (tail_sum - SUM_W'(QUEUE_DEPTH)) : tail_sum;
    assign tail      = tail_wrap[QIDX_W-1:0];

    always_comb begin
        n_head = r_head;
        n_used = r_used;
        if (i_req.push && !full) begin
            n_used = r_used + QCNT_W'(1);
        end else if (i_req.pop && !empty) begin
            n_used = r_used - QCNT_W'(1);
            n_head = (r_head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + QIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_used <= '0;
        end else begin
            r_head <= n_head;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push && !full) begin
            r_store[tail] <= i_req.code;
        end
    end

    assign o_stat.full      = full;
    assign o_stat.empty     = empty;
    assign o_stat.head_code = r_store[r_head];
    assign o_stat.used      = r_used;

endmodule

// ===== hw/rtl/kbsr_link.sv =====
module kbsr_link
    import kbsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  logic [7:0] i_empty_code,
    input  logic [7:0] i_poll_limit,
    input  t_q_stat   i_q_stat,
    output t_q_req    o_q_req,
    output t_out_item o_result
);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_rx_byte, n_rx_byte;
    logic [7:0]       r_reply, n_reply;
    logic             r_clock, n_clock;
    logic             r_data, n_data;
    logic             r_drive, n_drive;

    logic [2:0]        action;
    logic [1:0]        watch;
    logic              push_ok;
    logic              pop;
    logic [7:0]        deq_code;
    logic [CNT_W-1:0]  limit;
    logic [2:0]        bit_sel;
    logic [QCNT_W-1:0] used_after;

    assign deq_code = i_q_stat.empty ? i_empty_code : i_q_stat.head_code;
    assign limit    = i_poll_limit[7] ? COUNT_MAX : i_poll_limit[CNT_W-1:0];
    // MSB first: tick pair k carries bit 7-k
    assign bit_sel  = ~r_count[3:1];

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_rx_byte = r_rx_byte;
        n_reply   = r_reply;
        n_clock   = r_clock;
        n_data    = r_data;
        n_drive   = r_drive;
        action    = ACT_NONE;
        watch     = WATCH_KEEP;
        push_ok   = 1'b0;
        pop       = 1'b0;
        case (t_func'(i_item.func))
            FUNC_PUSH: begin
                push_ok = !i_q_stat.full;
            end
            FUNC_EDGE: begin
                if (r_phase == PH_WAIT_RX && !i_item.data_line_level) begin
                    action    = ACT_RX_TIMING;
                    watch     = WATCH_STOP;
                    n_rx_byte = '0;
                    n_count   = '0;
                    n_phase   = PH_RECEIVE;
                end else if (r_phase == PH_WAIT_TX && i_item.data_line_level) begin
                    watch   = WATCH_STOP;
                    n_drive = 1'b1;
                    n_count = '0;
                    if (r_rx_byte == CMD_INQUIRY) begin
                        action  = ACT_POLL;
                        n_reply = i_empty_code;
                        n_phase = PH_POLL;
                    end else begin
                        action  = ACT_TX_TIMING;
                        n_phase = PH_TRANSMIT;
                        case (r_rx_byte)
                            CMD_INSTANT: begin
                                n_reply = deq_code;
                                pop     = 1'b1;
                            end
                            CMD_MODEL: n_reply = REPLY_MODEL;
                            CMD_TEST:  n_reply = REPLY_ACK;
                            default:   n_reply = i_empty_code;
                        endcase
                    end
                end
            end
            FUNC_TICK: begin
                if (r_phase == PH_RECEIVE) begin
                    n_clock = r_count[0];
                    if (r_count[0]) begin
                        n_rx_byte[bit_sel] = r_rx_byte[bit_sel] | i_item.data_line_level;
                    end
                    if (r_count >= LAST_TICK) begin
                        action  = ACT_STOP;
                        watch   = WATCH_RISING;
                        n_phase = PH_WAIT_TX;
                    end
                    n_count = r_count + CNT_W'(1);
                end else if (r_phase == PH_POLL) begin
                    n_reply = deq_code;
                    pop     = 1'b1;
                    // a stored null code counts as nothing arrived
                    if (deq_code != i_empty_code || r_count >= limit) begin
                        action  = ACT_TX_PERIOD;
                        n_count = '0;
                        n_phase = PH_TRANSMIT;
                    end else if (r_count < COUNT_MAX) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (r_phase == PH_TRANSMIT) begin
                    n_clock = r_count[0];
                    if (!r_count[0]) begin
                        n_data = r_reply[bit_sel];
                    end
                    if (r_count >= LAST_TICK) begin
                        action  = ACT_STOP;
                        n_drive = 1'b0;
                        watch   = WATCH_FALLING;
                        n_phase = PH_WAIT_RX;
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT_RX;
            r_count   <= '0;
            r_rx_byte <= '0;
            r_reply   <= REPLY_RESET;
            r_clock   <= 1'b1;
            r_data    <= 1'b0;
            r_drive   <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_rx_byte <= n_rx_byte;
            r_reply   <= n_reply;
            r_clock   <= n_clock;
            r_data    <= n_data;
            r_drive   <= n_drive;
        end
    end

    assign o_q_req.push = i_fire && push_ok;
    assign o_q_req.pop  = i_fire && pop && !i_q_stat.empty;
    assign o_q_req.code = i_item.key_code;

    always_comb begin
        used_after = i_q_stat.used;
        if (push_ok) begin
            used_after = i_q_stat.used + QCNT_W'(1);
        end else if (pop && !i_q_stat.empty) begin
            used_after = i_q_stat.used - QCNT_W'(1);
        end
    end

    assign o_result.clock_level    = n_clock;
    assign o_result.data_out_level = n_drive & n_data;
    assign o_result.data_drive     = n_drive;
    assign o_result.timer_action   = action;
    assign o_result.edge_watch     = watch;
    assign o_result.push_accepted  = push_ok;
    assign o_result.queue_count    = QCOUNT_OUT_W'(used_after);
    assign o_result.phase          = phase_code(n_phase);

endmodule

// ===== hw/rtl/keyboard_serial_responder_unit.sv =====
// Each item is held in the input register, then its result in the output register.
// Throughput: one item per cycle while results are taken; a stalled result holds one more item.
// Every item gives exactly one result; link state and key queue update as it is stored.
// Reset (i_rst_n low at a clock edge): pipeline empty, queue empty, phase wait-for-receive,
// clock line high, data released, registers back to null code 123 and poll limit 100.
module keyboard_serial_responder_unit
    import kbsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic [7:0] r_empty_code;
    logic [7:0] r_poll_limit;

    logic      stage_fire;
    t_q_req    q_req;
    t_q_stat   q_stat;
    t_out_item result;

    assign stage_fire = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || stage_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_code <= EMPTY_CODE_RST;
            r_poll_limit <= POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_EMPTY_CODE: r_empty_code <= i_cfg_data;
                CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kbsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .o_stat  (q_stat)
    );

    kbsr_link u_link (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (stage_fire),
        .i_item       (r_in),
        .i_empty_code (r_empty_code),
        .i_poll_limit (r_poll_limit),
        .i_q_stat     (q_stat),
        .o_q_req      (q_req),
        .o_result     (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/kbsr_checker.sv =====
`include "keyboard_serial_responder_unit_macros.svh"

module kbsr_checker
    import kbsr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_item  o_out
);

    logic out_stall;
    logic out_released;
    logic count_ok;
    logic push_shown;
    logic push_quiet;

    assign out_stall    = o_out_valid && !i_out_ready;
    assign out_released = o_out_valid && !o_out.data_drive;
    assign count_ok     = (o_out.queue_count <= QCOUNT_OUT_W'(QUEUE_DEPTH));
    assign push_shown   = o_out_valid && o_out.push_accepted;
    assign push_quiet   = (o_out.timer_action == ACT_NONE) && (o_out.edge_watch == WATCH_KEEP);

    // stalled result holds
    `KSRU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out))

    // data level is forced low whenever the line is released
    `KSRU_ASSERT_NOW(a_release_low, i_clk, i_rst_n, out_released, !o_out.data_out_level)

    // queue never reports more codes than it can hold
    `KSRU_ASSERT_NOW(a_count_max, i_clk, i_rst_n, o_out_valid, count_ok)

    // a stored push never comes with timer or edge requests
    `KSRU_ASSERT_NOW(a_push_quiet, i_clk, i_rst_n, push_shown, push_quiet)

endmodule

bind keyboard_serial_responder_unit kbsr_checker u_kbsr_checker (.*);

// ===== sim/tb_top.sv =====
module tb_top;
    import kbsr_pkg::*;

    typedef struct packed {
        logic [7:0]                    empty_code;
        logic [7:0]                    poll_limit;
        t_phase_code                   ph;
        logic [CNT_W-1:0]              cnt;
        logic [7:0]                    rx_byte;
        logic [7:0]                    reply;
        logic [QUEUE_DEPTH-1:0][7:0]   store;
        logic [QIDX_W-1:0]             head;
        logic [QCNT_W-1:0]             used;
        logic                          clk_l;
        logic                          dat;
        logic                          drv;
    } t_link_state;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = CFG_EMPTY_CODE;
    logic [7:0] cfg_data = '0;

    t_in_item    item_q[$];
    t_out_item   expected_reports[$];
    t_link_state link_now;   // follows accepted transfers
    t_link_state link_plan;  // follows generated items, used to shape stimulus
    int          n_gen = 0;
    int          n_acc = 0;
    int          errors = 0;
    logic        in_taken = 1'b0;
    bit          idle_on = 1'b1;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    keyboard_serial_responder_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic t_link_state link_reset();
        t_link_state s;
        s = '0;
        s.empty_code = EMPTY_CODE_RST;
        s.poll_limit = POLL_LIMIT_RST;
        s.ph         = PCODE_WAIT_RX;
        s.reply      = REPLY_RESET;
        s.clk_l      = 1'b1;
        return s;
    endfunction

    // Empty queue yields the null code and leaves the queue alone.
    function automatic logic [7:0] take_key(inout t_link_state s);
        logic [7:0] code;
        if (s.used == 0)
            return s.empty_code;
        code = s.store[s.head];
        s.used = s.used - 1'b1;
        s.head = s.head + 1'b1;
        return code;
    endfunction

    function automatic t_out_item link_step(inout t_link_state s, input t_in_item it);
        t_out_item        r;
        logic [3:0]       c;
        logic [CNT_W-1:0] lim;
        logic [7:0]       code;
        r = '0;
        r.timer_action = ACT_NONE;
        r.edge_watch   = WATCH_KEEP;
        c = s.cnt[3:0];
        case (it.func)
            FUNC_PUSH: begin
                if (s.used < QUEUE_DEPTH) begin
                    s.store[s.head + QIDX_W'(s.used)] = it.key_code;
                    s.used = s.used + 1'b1;
                    r.push_accepted = 1'b1;
                end
            end
            FUNC_EDGE: begin
                if (s.ph == PCODE_WAIT_RX && !it.data_line_level) begin
                    r.timer_action = ACT_RX_TIMING;
                    r.edge_watch   = WATCH_STOP;
                    s.rx_byte      = '0;
                    s.cnt          = '0;
                    s.ph           = PCODE_RECEIVE;
                end else if (s.ph == PCODE_WAIT_TX && it.data_line_level) begin
                    r.edge_watch = WATCH_STOP;
                    s.drv        = 1'b1;
                    s.cnt        = '0;
                    if (s.rx_byte == CMD_INQUIRY) begin
                        r.timer_action = ACT_POLL;
                        s.reply        = s.empty_code;
                        s.ph           = PCODE_POLL;
                    end else begin
                        r.timer_action = ACT_TX_TIMING;
                        case (s.rx_byte)
                            CMD_INSTANT: begin
                                code    = take_key(s);
                                s.reply = code;
                            end
                            CMD_MODEL: s.reply = REPLY_MODEL;
                            CMD_TEST:  s.reply = REPLY_ACK;
                            default:   s.reply = s.empty_code;
                        endcase
                        s.ph = PCODE_TRANSMIT;
                    end
                end
            end
            FUNC_TICK: begin
                if (s.ph == PCODE_RECEIVE) begin
                    s.clk_l = c[0];
                    if (c[0])
                        s.rx_byte[3'd7 - c[3:1]] = s.rx_byte[3'd7 - c[3:1]] | it.data_line_level;
                    if (s.cnt >= LAST_TICK) begin
                        r.timer_action = ACT_STOP;
                        r.edge_watch   = WATCH_RISING;
                        s.ph           = PCODE_WAIT_TX;
                    end
                    s.cnt = s.cnt + 1'b1;
                end else if (s.ph == PCODE_POLL) begin
                    // counter is 7 bits, so larger limits act as the counter maximum
                    lim     = (s.poll_limit > 8'(COUNT_MAX)) ? COUNT_MAX : s.poll_limit[CNT_W-1:0];
                    code    = take_key(s);
                    s.reply = code;
                    if (code != s.empty_code || s.cnt >= lim) begin
                        r.timer_action = ACT_TX_PERIOD;
                        s.cnt          = '0;
                        s.ph           = PCODE_TRANSMIT;
                    end else if (s.cnt < COUNT_MAX) begin
                        s.cnt = s.cnt + 1'b1;
                    end
                end else if (s.ph == PCODE_TRANSMIT) begin
                    s.clk_l = c[0];
                    if (!c[0])
                        s.dat = s.reply[3'd7 - c[3:1]];
                    if (s.cnt >= LAST_TICK) begin
                        r.timer_action = ACT_STOP;
                        r.edge_watch   = WATCH_FALLING;
                        s.drv          = 1'b0;
                        s.ph           = PCODE_WAIT_RX;
                    end
                    s.cnt = s.cnt + 1'b1;
                end
            end
            default: ;
        endcase
        r.clock_level    = s.clk_l;
        r.data_out_level = s.drv & s.dat;
        r.data_drive     = s.drv;
        r.queue_count    = 5'(s.used);
        r.phase          = s.ph;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] expv, logic [7:0] actv);
        if (expv !== actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            errors++;
        end
    endtask

    // transfer monitor: prediction on input side, comparison on result side
    always @(posedge clk) begin
        t_out_item e;
        if (rst_n) begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                expected_reports.push_back(link_step(link_now, in_item));
                n_acc++;
            end
            if (out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    errors++;
                end else begin
                    e = expected_reports.pop_front();
                    check_field("clock_level", e.clock_level, out_item.clock_level);
                    check_field("data_out_level", e.data_out_level, out_item.data_out_level);
                    check_field("data_drive", e.data_drive, out_item.data_drive);
                    check_field("timer_action", e.timer_action, out_item.timer_action);
                    check_field("edge_watch", e.edge_watch, out_item.edge_watch);
                    check_field("push_accepted", e.push_accepted, out_item.push_accepted);
                    check_field("queue_count", e.queue_count, out_item.queue_count);
                    check_field("phase", e.phase, out_item.phase);
                end
            end
        end
    end

    // input driver
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (idle_on && item_q.size() != 0 && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(1, 10) - 1;
                in_valid <= 1'b0;
            end else if (item_q.size() != 0) begin
                in_item  <= item_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic offer(t_func f, logic lvl, logic [7:0] key);
        t_in_item   it;
        t_out_item  unused;
        it.func            = f;
        it.data_line_level = lvl;
        it.key_code        = key;
        unused = link_step(link_plan, it);
        item_q.push_back(it);
        n_gen++;
    endtask

    function automatic logic [7:0] pick_key();
        return ($urandom_range(0, 7) == 0) ? link_plan.empty_code : 8'($urandom);
    endfunction

    // Items that the link ignores in the wait phase, plus pushes.
    task automatic idle_chatter();
        int n;
        int k;
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0:       offer(FUNC_NOP, 1'($urandom), 8'($urandom));
                1:       offer(FUNC_TICK, 1'($urandom), 8'($urandom));
                2:       offer(FUNC_EDGE, 1'b1, 8'($urandom));
                default: offer(FUNC_PUSH, 1'($urandom), pick_key());
            endcase
        end
    endtask

    // One command byte in, one reply byte out.
    task automatic byte_exchange(logic [7:0] cmd);
        int i;
        int r;
        offer(FUNC_EDGE, 1'b0, 8'($urandom));
        for (i = 0; i < 2 * BITS_PER_BYTE; i++) begin
            r = $urandom_range(0, 11);
            if (r == 0)
                offer(FUNC_EDGE, 1'($urandom), 8'($urandom));
            else if (r == 1)
                offer(FUNC_PUSH, 1'($urandom), pick_key());
            // odd ticks sample the bit, even ticks carry a don't-care level
            offer(FUNC_TICK, (i % 2 == 1) ? cmd[7 - i / 2] : 1'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 3) == 0)
            offer(FUNC_TICK, 1'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) == 0)
            offer(FUNC_EDGE, 1'b0, 8'($urandom));
        offer(FUNC_EDGE, 1'b1, 8'($urandom));
        while (link_plan.ph != PCODE_WAIT_RX) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                offer(FUNC_PUSH, 1'($urandom), pick_key());
            else if (r == 1)
                offer(FUNC_EDGE, 1'($urandom), 8'($urandom));
            else
                offer(FUNC_TICK, 1'($urandom), 8'($urandom));
        end
    endtask

    function automatic logic [7:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)      return CMD_INQUIRY;
        else if (r < 55) return CMD_INSTANT;
        else if (r < 65) return CMD_MODEL;
        else if (r < 75) return CMD_TEST;
        else             return 8'($urandom);
    endfunction

    task automatic random_traffic(int n_items);
        int target;
        target = n_gen + n_items;
        while (n_gen < target) begin
            idle_chatter();
            byte_exchange(pick_command());
        end
    endtask

    task automatic drain();
        while (n_acc != n_gen || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == CFG_EMPTY_CODE) begin
            link_now.empty_code  = val;
            link_plan.empty_code = val;
        end else begin
            link_now.poll_limit  = val;
            link_plan.poll_limit = val;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        link_now  = link_reset();
        link_plan = link_reset();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: ignored items, key extremes, a null code sitting in the queue
        offer(FUNC_NOP, 1'b1, 8'hFF);
        offer(FUNC_TICK, 1'b0, 8'h00);
        offer(FUNC_EDGE, 1'b1, 8'h00);
        offer(FUNC_PUSH, 1'b1, 8'hFF);
        offer(FUNC_PUSH, 1'b0, EMPTY_CODE_RST);
        offer(FUNC_PUSH, 1'b0, 8'h00);
        byte_exchange(CMD_INSTANT);
        byte_exchange(CMD_INQUIRY);
        drain();

        write_reg(CFG_EMPTY_CODE, 8'h00);
        write_reg(CFG_POLL_LIMIT, 8'd1);
        random_traffic(400);
        drain();

        // long receiver hold-off while the sender keeps going
        write_reg(CFG_EMPTY_CODE, 8'hFF);
        write_reg(CFG_POLL_LIMIT, 8'd255);
        idle_on = 1'b0;
        hold_reqs++;
        random_traffic(400);
        drain();

        write_reg(CFG_EMPTY_CODE, 8'($urandom));
        write_reg(CFG_POLL_LIMIT, 8'd128);
        idle_on = 1'b1;
        random_traffic(400);
        drain();

        write_reg(CFG_EMPTY_CODE, EMPTY_CODE_RST);
        write_reg(CFG_POLL_LIMIT, 8'd5);
        random_traffic(400);
        drain();

        write_reg(CFG_POLL_LIMIT, POLL_LIMIT_RST);
        idle_on = 1'b0;
        random_traffic(400);
        drain();

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_reports.size() == 0)
            $display("[keyboard_serial_responder_unit] OK");
        else
            $display("[keyboard_serial_responder_unit] ERROR");
        $finish;
    end

    initial begin
        #12000000;
        $display("[keyboard_serial_responder_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/kbsr_pkg.sv
hw/rtl/kbsr_queue.sv
hw/rtl/kbsr_link.sv
hw/rtl/keyboard_serial_responder_unit.sv
hw/rtl/kbsr_checker.sv
sim/tb_top.sv
